/* rtl/core/blpb_pkg.sv */
// Shared types, widths and constants for the band level and peak ballistics block.
`timescale 1ns / 1ps

package blpb_pkg;

    // Field widths
    localparam int BAND_W  = 5;
    localparam int LVL_W   = 16;
    localparam int TICK_W  = 15;
    localparam int RATE_W  = 16;
    localparam int AGE_W   = 20;
    localparam int DEC_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Default number of bands held in the store
    localparam int NUM_BANDS_DEF = 32;

    // Longest tick that is honoured (0.25 s) and the ceiling of the peak age
    localparam logic [TICK_W-1:0] MAX_TICK = 15'd16384;
    localparam logic [AGE_W-1:0]  AGE_MAX  = 20'hFFFFF;

    // Store contents after reset
    localparam logic signed [LVL_W-1:0] LVL_RESET = -16'sd25600;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALL_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING_LEVEL  = 3'd4;

    // Configuration register reset values
    localparam logic [RATE_W-1:0]       FALL_RATE_RST      = 16'd10240;
    localparam logic [RATE_W-1:0]       PEAK_FALL_RATE_RST = 16'd6400;
    localparam logic [AGE_W-1:0]        HOLD_TIME_RST      = 20'd52429;
    localparam logic signed [LVL_W-1:0] FLOOR_LEVEL_RST    = -16'sd25600;
    localparam logic signed [LVL_W-1:0] CEILING_LEVEL_RST  = 16'sd0;

    // Current configuration
    typedef struct packed {
        logic [RATE_W-1:0]       fall_rate;
        logic [RATE_W-1:0]       peak_fall_rate;
        logic [AGE_W-1:0]        hold_time;
        logic signed [LVL_W-1:0] floor_level;
        logic signed [LVL_W-1:0] ceiling_level;
    } t_cfg;

    // Per-band ballistics state
    typedef struct packed {
        logic signed [LVL_W-1:0] level;
        logic signed [LVL_W-1:0] peak;
        logic [AGE_W-1:0]        age;
    } t_band_state;

    localparam t_band_state BAND_STATE_RST = '{level: LVL_RESET, peak: LVL_RESET, age: '0};

endpackage

/* rtl/core/band_level_peak_ballistics.sv */
// Top level of the per-band meter ballistics block with peak hold and decay.
`timescale 1ns / 1ps

// One band update is accepted every clock cycle while the output side does not
// stall, and each beat gives one result beat through the update stage registers
// and then the result register. The band state lives in a memory with a registered
// read; the update of a band is a read-modify-write, and a beat for the same band as
// the one just before it takes the freshly written state from a forwarding register.
// Entries read as LVL_RESET and zero age until first written, so no clearing pass runs
// after reset. Levels are Q8.8 dB, times are in 1/65536 s; ticks above 0.25 s
// count as 0.25 s. A band index at or above NUM_BANDS changes nothing and
// returns the floor level for both level and peak.

module band_level_peak_ballistics
    import blpb_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: band [4:0], target_level [20:5], tick_time [35:21], zero [39:36]
    input  logic [39:0]           i_s_tdata,
    // tuser: new_audio [0]
    input  logic                  i_s_tuser,
    // Result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: band_out [4:0], level_out [20:5], peak_out [36:21], zero [39:37]
    output logic [39:0]           o_m_tdata
);

    localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    t_cfg cfg;

    logic [BAND_W-1:0]       in_band;
    logic signed [LVL_W-1:0] in_target;
    logic [TICK_W-1:0]       in_tick;
    logic [TICK_W-1:0]       tick_sat;
    logic signed [LVL_W-1:0] target_sel;
    logic                    in_range;
    logic [31:0]             fall_prod;
    logic [31:0]             pfall_prod;

    logic s_acc;
    logic out_free;
    logic s1_move;

    // Update stage registers
    logic                    r_s1_valid;
    logic [BAND_W-1:0]       r_s1_band;
    logic                    r_s1_inrange;
    logic signed [LVL_W-1:0] r_s1_target;
    logic [TICK_W-1:0]       r_s1_tick;
    logic [DEC_W-1:0]        r_s1_dec;
    logic [DEC_W-1:0]        r_s1_pdec;
    logic                    r_fwd_hit;
    t_band_state             r_fwd_state;

    // Result register
    logic                    r_out_valid;
    logic [BAND_W-1:0]       r_out_band;
    logic signed [LVL_W-1:0] r_out_level;
    logic signed [LVL_W-1:0] r_out_peak;

    t_band_state mem_state;
    t_band_state cur_state;
    t_band_state upd_state;

    blpb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Beat unpacking, tick saturation and the floor for stale targets
    assign in_band    = i_s_tdata[4:0];
    assign in_target  = $signed(i_s_tdata[20:5]);
    assign in_tick    = i_s_tdata[35:21];
    assign tick_sat   = (in_tick > MAX_TICK) ? MAX_TICK : in_tick;
    assign target_sel = i_s_tuser ? in_target : cfg.floor_level;
    assign in_range   = (32'(in_band) < NUM_BANDS);

    // Fall amounts, rounded half up to Q8.8; they depend only on rate and tick.
    assign fall_prod  = 32'(cfg.fall_rate) * 32'(tick_sat) + 32'd32768;
    assign pfall_prod = 32'(cfg.peak_fall_rate) * 32'(tick_sat) + 32'd32768;

    // Handshake: the result register parts the update stage from the output.
    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;

    blpb_state_mem #(
        .NUM_BANDS (NUM_BANDS)
    ) u_state_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_acc),
        .i_rd_idx   (BAND_IDX_W'(in_band)),
        .o_rd_state (mem_state),
        .i_wr_en    (s1_move && r_s1_inrange),
        .i_wr_idx   (BAND_IDX_W'(r_s1_band)),
        .i_wr_state (upd_state)
    );

    // Update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Update stage payload; a beat for the band being written takes forwarded state.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_band    <= in_band;
            r_s1_inrange <= in_range;
            r_s1_target  <= target_sel;
            r_s1_tick    <= tick_sat;
            r_s1_dec     <= fall_prod[30:16];
            r_s1_pdec    <= pfall_prod[30:16];
            r_fwd_hit    <= s1_move && r_s1_inrange && (r_s1_band == in_band);
        end
        if (s1_move) begin
            r_fwd_state <= upd_state;
        end
    end

    assign cur_state = r_fwd_hit ? r_fwd_state : mem_state;

    blpb_update u_update (
        .i_cfg    (cfg),
        .i_state  (cur_state),
        .i_target (r_s1_target),
        .i_tick   (r_s1_tick),
        .i_dec    (r_s1_dec),
        .i_pdec   (r_s1_pdec),
        .o_state  (upd_state)
    );

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; out-of-range bands report the floor level.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_band  <= r_s1_band;
            r_out_level <= r_s1_inrange ? upd_state.level : cfg.floor_level;
            r_out_peak  <= r_s1_inrange ? upd_state.peak  : cfg.floor_level;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_peak, r_out_level, r_out_band};

endmodule

/* rtl/core/blpb_cfg_regs.sv */
// Configuration register file for the band level and peak ballistics block.
`timescale 1ns / 1ps

module blpb_cfg_regs
    import blpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken at once.
    assign o_cfg_ready = 1'b1;

    // Register decode; indexes beyond the list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FALL_RATE:      n_cfg.fall_rate      = i_cfg_data[RATE_W-1:0];
                REG_PEAK_FALL_RATE: n_cfg.peak_fall_rate = i_cfg_data[RATE_W-1:0];
                REG_HOLD_TIME:      n_cfg.hold_time      = i_cfg_data[AGE_W-1:0];
                REG_FLOOR_LEVEL:    n_cfg.floor_level    = $signed(i_cfg_data[LVL_W-1:0]);
                REG_CEILING_LEVEL:  n_cfg.ceiling_level  = $signed(i_cfg_data[LVL_W-1:0]);
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_rate      <= FALL_RATE_RST;
            r_cfg.peak_fall_rate <= PEAK_FALL_RATE_RST;
            r_cfg.hold_time      <= HOLD_TIME_RST;
            r_cfg.floor_level    <= FLOOR_LEVEL_RST;
            r_cfg.ceiling_level  <= CEILING_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/blpb_state_mem.sv */
// Per-band state memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module blpb_state_mem
    import blpb_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF,
    localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [BAND_IDX_W-1:0] i_rd_idx,
    output t_band_state           o_rd_state,
    input  logic                  i_wr_en,
    input  logic [BAND_IDX_W-1:0] i_wr_idx,
    input  t_band_state           i_wr_state
);

    t_band_state          r_mem [NUM_BANDS];
    t_band_state          r_rd_data;
    logic                 r_rd_vld;
    logic [NUM_BANDS-1:0] r_valid;

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_state;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
            r_rd_vld  <= r_valid[i_rd_idx];
        end
    end

    // Valid bits: an entry never written reads as the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_state = r_rd_vld ? r_rd_data : BAND_STATE_RST;

endmodule

/* rtl/core/blpb_update.sv */
// Level fall, clamp, peak hold and peak fall for one band update.
`timescale 1ns / 1ps

module blpb_update
    import blpb_pkg::*;
(
    input  t_cfg                    i_cfg,
    input  t_band_state             i_state,
    input  logic signed [LVL_W-1:0] i_target,
    input  logic [TICK_W-1:0]       i_tick,
    input  logic [DEC_W-1:0]        i_dec,
    input  logic [DEC_W-1:0]        i_pdec,
    output t_band_state             o_state
);

    logic signed [17:0]      lvl_dec;
    logic signed [17:0]      cand_max;
    logic signed [17:0]      cand_floor;
    logic signed [17:0]      cand_ceil;
    logic signed [LVL_W-1:0] lvl_new;
    logic [AGE_W:0]          age_sum;
    logic [AGE_W-1:0]        age_sat;
    logic signed [16:0]      pk_dec;
    logic signed [16:0]      lvl_new_ext;

    // Displayed level: decayed old level against target, then floor, then ceiling.
    always_comb begin
        lvl_dec    = 18'(i_state.level) - $signed({3'b000, i_dec});
        cand_max   = (18'(i_target) > lvl_dec) ? 18'(i_target) : lvl_dec;
        cand_floor = (cand_max < 18'(i_cfg.floor_level)) ? 18'(i_cfg.floor_level) : cand_max;
        cand_ceil  = (cand_floor > 18'(i_cfg.ceiling_level)) ?
                     18'(i_cfg.ceiling_level) : cand_floor;
        lvl_new    = cand_ceil[LVL_W-1:0];
    end

    // Peak: follow the level upward, otherwise age and fall after the hold time.
    always_comb begin
        age_sum     = {1'b0, i_state.age} + (AGE_W+1)'(i_tick);
        age_sat     = (age_sum > (AGE_W+1)'(AGE_MAX)) ? AGE_MAX : age_sum[AGE_W-1:0];
        pk_dec      = 17'(i_state.peak) - $signed({2'b00, i_pdec});
        lvl_new_ext = 17'(lvl_new);
        o_state.level = lvl_new;
        if (lvl_new >= i_state.peak) begin
            o_state.peak = lvl_new;
            o_state.age  = '0;
        end else begin
            o_state.age = age_sat;
            if (age_sat > i_cfg.hold_time) begin
                o_state.peak = (pk_dec < lvl_new_ext) ? lvl_new : pk_dec[LVL_W-1:0];
            end else begin
                o_state.peak = i_state.peak;
            end
        end
    end

endmodule

/* dv/band_level_peak_ballistics_tb.sv */
// Self-checking testbench for the per-band meter ballistics block with peak hold and decay.
`timescale 1ns / 1ps

module band_level_peak_ballistics_tb;
    import blpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;
    localparam int DRAIN_CYCLES   = 6;

    // One result beat split into its fields.
    typedef struct packed {
        logic [BAND_W-1:0]       band;
        logic signed [LVL_W-1:0] level;
        logic signed [LVL_W-1:0] peak;
    } t_meter_reading;

    // DUT inputs, all at known values from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [39:0]           i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [39:0]           o_m_tdata;

    // Own copy of the configuration and of the per-band stores.
    logic [RATE_W-1:0]       cfg_fall_rate;
    logic [RATE_W-1:0]       cfg_peak_fall_rate;
    logic [AGE_W-1:0]        cfg_hold_time;
    logic signed [LVL_W-1:0] cfg_floor;
    logic signed [LVL_W-1:0] cfg_ceiling;
    logic signed [LVL_W-1:0] meter_level [NUM_BANDS_DEF];
    logic signed [LVL_W-1:0] meter_peak  [NUM_BANDS_DEF];
    logic [AGE_W-1:0]        meter_age   [NUM_BANDS_DEF];

    t_meter_reading readings_due[$];
    t_meter_reading seen_reading;
    t_meter_reading owed_reading;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int sink_hold      = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    band_level_peak_ballistics u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Amount of fall over one tick, rounded half up to Q8.8.
    function automatic int fall_amount(input logic [RATE_W-1:0] rate, input int unsigned t);
        int unsigned product;
        product = rate * t + 32'd32768;
        return int'(product >> 16);
    endfunction

    // Applies one band update to the local stores and returns the expected result.
    function automatic t_meter_reading predict_band_update(
        input logic [BAND_W-1:0]       band,
        input logic signed [LVL_W-1:0] target,
        input logic                    fresh,
        input logic [TICK_W-1:0]       tick
    );
        int             tgt;
        int             lvl;
        int             pk;
        int             cand;
        int unsigned    t;
        int unsigned    age;
        t_meter_reading r;
        t   = (tick > MAX_TICK) ? MAX_TICK : tick;
        tgt = fresh ? int'(target) : int'(cfg_floor);
        lvl = meter_level[band];
        pk  = meter_peak[band];
        age = meter_age[band];

        // Level: decayed old level or the new target, whichever is higher, then clamped.
        cand = lvl - fall_amount(cfg_fall_rate, t);
        if (tgt > cand) cand = tgt;
        if (cand < cfg_floor) cand = cfg_floor;
        if (cand > cfg_ceiling) cand = cfg_ceiling;
        lvl = cand;

        // Peak: follow upward, otherwise age and fall once the hold has run out.
        if (lvl >= pk) begin
            pk  = lvl;
            age = 0;
        end else begin
            age = age + t;
            if (age > AGE_MAX) age = AGE_MAX;
            if (age > cfg_hold_time) begin
                pk = pk - fall_amount(cfg_peak_fall_rate, t);
                if (pk < lvl) pk = lvl;
            end
        end

        meter_level[band] = LVL_W'(lvl);
        meter_peak[band]  = LVL_W'(pk);
        meter_age[band]   = AGE_W'(age);
        r.band  = band;
        r.level = LVL_W'(lvl);
        r.peak  = LVL_W'(pk);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("mismatch: %s expected %0d got %0d", what, want, got);
        end
    endtask

    // Sends one band update beat, with a random gap before it.
    task automatic send_band_update(
        input logic [BAND_W-1:0]       band,
        input logic signed [LVL_W-1:0] target,
        input logic                    fresh,
        input logic [TICK_W-1:0]       tick
    );
        int gap;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, tick, target, band};
        i_s_tuser  <= fresh;
        do @(posedge i_clk); while (!o_s_tready);
        readings_due.push_back(predict_band_update(band, target, fresh, tick));
    endtask

    // Drives one register write beat; the caller lowers valid after a run of writes.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FALL_RATE:      cfg_fall_rate      = value[RATE_W-1:0];
            REG_PEAK_FALL_RATE: cfg_peak_fall_rate = value[RATE_W-1:0];
            REG_HOLD_TIME:      cfg_hold_time      = value[AGE_W-1:0];
            REG_FLOOR_LEVEL:    cfg_floor          = value[LVL_W-1:0];
            REG_CEILING_LEVEL:  cfg_ceiling        = value[LVL_W-1:0];
            default: ;
        endcase
    endtask

    // Stops the input stream and waits until every result has been seen.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the whole register set; the unused upper data bits of the 16-bit registers carry noise.
    task automatic apply_config(input t_cfg c);
        write_register(REG_FALL_RATE,      {4'($urandom), c.fall_rate});
        write_register(REG_PEAK_FALL_RATE, {4'($urandom), c.peak_fall_rate});
        write_register(REG_HOLD_TIME,      c.hold_time);
        write_register(REG_FLOOR_LEVEL,    {4'($urandom), c.floor_level});
        write_register(REG_CEILING_LEVEL,  {4'($urandom), c.ceiling_level});
        i_cfg_valid <= 1'b0;
    endtask

    // Targets mostly fall inside the displayed range, some anywhere.
    function automatic logic signed [LVL_W-1:0] random_target();
        int lo;
        int hi;
        lo = (cfg_floor < cfg_ceiling) ? cfg_floor : cfg_ceiling;
        hi = (cfg_floor < cfg_ceiling) ? cfg_ceiling : cfg_floor;
        if ($urandom_range(0, 3) == 0) begin
            return LVL_W'($urandom);
        end
        return LVL_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic [TICK_W-1:0] random_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return TICK_W'($urandom);
        if (r < 15) return MAX_TICK;
        return TICK_W'($urandom_range(0, 4000));
    endfunction

    // A few bands get most of the traffic so that state builds up.
    task automatic run_random_items(input int count);
        logic [BAND_W-1:0] band;
        for (int n = 0; n < count; n++) begin
            band = ($urandom_range(0, 1) == 0) ? BAND_W'($urandom_range(0, 3))
                                               : BAND_W'($urandom);
            send_band_update(band, random_target(), $urandom_range(0, 9) < 7, random_tick());
        end
    endtask

    // Field extremes, long ticks and the default hold and fall behaviour.
    task automatic test_field_extremes();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_band_update(0, 16'sh7FFF, 1'b1, 0);
        send_band_update(0, 16'sh7FFF, 1'b0, 16384);
        send_band_update(0, 16'sh7FFF, 1'b0, 15'h7FFF);
        send_band_update(0, 16'sh0000, 1'b0, 16385);
        send_band_update(0, 16'sh0000, 1'b0, 16384);
        send_band_update(0, 16'sh8000, 1'b1, 16384);
        send_band_update(31, 16'sh8000, 1'b1, 0);
        send_band_update(31, 16'sh7FFF, 1'b1, 0);
        send_band_update(31, 16'shFFFF, 1'b1, 1);
        src_gap_pct    = 50;
        sink_stall_pct = 50;
        send_band_update(21, 16'sh5555, 1'b1, 15'h2AAA);
        send_band_update(10, 16'shAAAA, 1'b1, 15'h5555);
        send_band_update(21, 16'shAAAA, 1'b0, 15'h5555);
        send_band_update(10, 16'sh5555, 1'b1, 15'h2AAA);
        send_band_update(16, 16'shC000, 1'b1, 8192);
        send_band_update(16, 16'shC000, 1'b0, 100);
        send_band_update(0, 16'sh0000, 1'b0, 16384);
        wait_for_results();
    endtask

    // A floor above the ceiling leaves the ceiling in charge.
    task automatic test_floor_above_ceiling();
        apply_config('{fall_rate: 16'd2000, peak_fall_rate: 16'd1000, hold_time: 20'd0,
                       floor_level: 16'sd1000, ceiling_level: -16'sd1000});
        send_band_update(3, 16'sh7FFF, 1'b1, 100);
        send_band_update(3, 16'sh8000, 1'b1, 16384);
        send_band_update(4, 16'sh0000, 1'b0, 0);
        send_band_update(3, 16'sh0000, 1'b0, 16384);
        wait_for_results();
    endtask

    // The peak age runs into its ceiling, then a hold just below it lets the peak fall.
    task automatic test_peak_age_saturation();
        apply_config('{fall_rate: 16'hFFFF, peak_fall_rate: 16'd0, hold_time: 20'hFFFFF,
                       floor_level: -16'sd32768, ceiling_level: 16'sd32767});
        src_gap_pct    = 10;
        sink_stall_pct = 10;
        send_band_update(9, 16'sh7FFF, 1'b1, 0);
        for (int n = 0; n < 70; n++) begin
            send_band_update(9, 16'sh8000, 1'b0, MAX_TICK);
        end
        wait_for_results();
        apply_config('{fall_rate: 16'hFFFF, peak_fall_rate: 16'hFFFF, hold_time: 20'hFFFFE,
                       floor_level: -16'sd32768, ceiling_level: 16'sd32767});
        for (int n = 0; n < 5; n++) begin
            send_band_update(9, 16'sh8000, 1'b0, MAX_TICK);
        end
        wait_for_results();
    endtask

    // Writes beyond the register list must leave the configuration alone.
    task automatic test_unlisted_registers();
        for (int idx = REG_CEILING_LEVEL + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_register(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        for (int n = 0; n < 8; n++) begin
            send_band_update(BAND_W'(n), random_target(), 1'b1, random_tick());
        end
        wait_for_results();
    endtask

    // Random traffic under a range of settings and idle patterns.
    task automatic test_random_sweep();
        t_cfg settings [8];
        settings[0] = '{fall_rate: FALL_RATE_RST, peak_fall_rate: PEAK_FALL_RATE_RST,
                        hold_time: HOLD_TIME_RST, floor_level: FLOOR_LEVEL_RST,
                        ceiling_level: CEILING_LEVEL_RST};
        settings[1] = '{fall_rate: 16'd0, peak_fall_rate: 16'd0, hold_time: 20'd0,
                        floor_level: -16'sd32768, ceiling_level: 16'sd32767};
        settings[2] = '{fall_rate: 16'hFFFF, peak_fall_rate: 16'hFFFF, hold_time: 20'd0,
                        floor_level: -16'sd32768, ceiling_level: 16'sd32767};
        settings[3] = '{fall_rate: 16'hFFFF, peak_fall_rate: 16'hFFFF, hold_time: 20'hFFFFF,
                        floor_level: -16'sd25600, ceiling_level: 16'sd0};
        settings[4] = '{fall_rate: 16'd300, peak_fall_rate: 16'd200, hold_time: 20'd8000,
                        floor_level: -16'sd6000, ceiling_level: -16'sd1000};
        settings[5] = '{fall_rate: 16'd5, peak_fall_rate: 16'd5, hold_time: 20'd100,
                        floor_level: 16'sd1234, ceiling_level: 16'sd1234};
        settings[6] = '{fall_rate: 16'($urandom), peak_fall_rate: 16'($urandom),
                        hold_time: 20'($urandom), floor_level: 16'($urandom),
                        ceiling_level: 16'($urandom)};
        settings[7] = '{fall_rate: 16'($urandom_range(0, 20000)),
                        peak_fall_rate: 16'($urandom_range(0, 20000)),
                        hold_time: 20'($urandom_range(0, 20000)),
                        floor_level: -16'sd20000, ceiling_level: 16'sd2000};
        for (int s = 0; s < 8; s++) begin
            apply_config(settings[s]);
            case (s % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 30; sink_stall_pct = 30; end
                2: begin src_gap_pct = 10; sink_stall_pct = 60; end
                default: begin src_gap_pct = 60; sink_stall_pct = 10; end
            endcase
            run_random_items(100);
            wait_for_results();
        end
    endtask

    // Result side: random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_hold  <= 0;
        end else if (sink_hold > 0) begin
            i_m_tready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            i_m_tready <= 1'b0;
            sink_hold  <= pick_gap() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Each result beat is checked against the oldest outstanding reading.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_reading.band  = o_m_tdata[4:0];
            seen_reading.level = o_m_tdata[20:5];
            seen_reading.peak  = o_m_tdata[36:21];
            if (readings_due.size() == 0) begin
                flag_mismatch("unexpected result beat, band", -1, seen_reading.band);
            end else begin
                owed_reading = readings_due.pop_front();
                if (seen_reading.band !== owed_reading.band) begin
                    flag_mismatch("band_out", owed_reading.band, seen_reading.band);
                end
                if (seen_reading.level !== owed_reading.level) begin
                    flag_mismatch("level_out", owed_reading.level, seen_reading.level);
                end
                if (seen_reading.peak !== owed_reading.peak) begin
                    flag_mismatch("peak_out", owed_reading.peak, seen_reading.peak);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat has moved for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_fall_rate      = FALL_RATE_RST;
        cfg_peak_fall_rate = PEAK_FALL_RATE_RST;
        cfg_hold_time      = HOLD_TIME_RST;
        cfg_floor          = FLOOR_LEVEL_RST;
        cfg_ceiling        = CEILING_LEVEL_RST;
        for (int b = 0; b < NUM_BANDS_DEF; b++) begin
            meter_level[b] = LVL_RESET;
            meter_peak[b]  = LVL_RESET;
            meter_age[b]   = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_floor_above_ceiling();
        test_peak_age_saturation();
        test_unlisted_registers();
        test_random_sweep();

        wait_for_results();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/blpb_pkg.sv
rtl/core/blpb_cfg_regs.sv
rtl/core/blpb_state_mem.sv
rtl/core/blpb_update.sv
rtl/core/band_level_peak_ballistics.sv
dv/band_level_peak_ballistics_tb.sv
